FILE: hw/rtl/i2cq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the queued I2C master sequencer.
// No dependencies.
package i2cq_pkg;

  // Operation codes as they arrive on the input channel.
  localparam logic [2:0] OPC_LOAD  = 3'd0;
  localparam logic [2:0] OPC_READ  = 3'd1;
  localparam logic [2:0] OPC_WRITE = 3'd2;
  localparam logic [2:0] OPC_REGRD = 3'd3;
  localparam logic [2:0] OPC_EVENT = 3'd4;

  // Length of the register-pointer write that opens a register read.
  localparam logic [7:0] REG_PTR_LEN = 8'd2;

  typedef enum logic [2:0] {
    OP_LOAD, OP_READ, OP_WRITE, OP_REGRD, OP_EVENT, OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    PH_WRITE = 2'd0,
    PH_REQ   = 2'd1,
    PH_READ  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_DESC2, ST_KICK, ST_ADV, ST_DRD,
    ST_MOD, ST_MEM, ST_RD, ST_DONE
  } state_t;

  // What to do once a byte store access completes.
  typedef enum logic [2:0] {
    AF_DONE, AF_ADV, AF_RVAL, AF_TX, AF_BEGIN
  } after_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] address;
    logic [7:0] length;
    logic [7:0] byte_value;
    logic       nack;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_value;
    logic       send_start;
    logic       send_stop;
    logic       receive_mode;
    logic       nak_next;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       stored;
    logic       engine_idle;
  } result_t;

endpackage

FILE: hw/rtl/i2cq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// No dependencies.
interface i2cq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] address;
  logic [7:0] length;
  logic [7:0] byte_value;
  logic       nack;

  modport source (output valid, operation, address, length, byte_value, nack,
                  input ready);
  modport sink   (input valid, operation, address, length, byte_value, nack,
                  output ready);
endinterface

interface i2cq_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [7:0] read_value;
  logic       send_start;
  logic       send_stop;
  logic       receive_mode;
  logic       nak_next;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       stored;
  logic       engine_idle;

  modport source (output valid, accepted, read_value, send_start, send_stop,
                  receive_mode, nak_next, tx_valid, tx_byte, stored, engine_idle,
                  input ready);
  modport sink   (input valid, accepted, read_value, send_start, send_stop,
                  receive_mode, nak_next, tx_valid, tx_byte, stored, engine_idle,
                  output ready);
endinterface

FILE: hw/rtl/i2cq_front.sv
`timescale 1ns / 1ps
// Front end: takes request transfers, decodes the operation code and holds
// them in a two-entry queue for the engine. Uses i2cq_pkg and i2cq_in_if.
module i2cq_front import i2cq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  i2cq_in_if.sink       in_ch,
  output logic          item_valid,
  output item_t         item,
  input  logic          item_pop
);

  localparam int FifoDepth = 2;

  item_t      fifo_r [FifoDepth];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      decoded;

  function automatic op_t decode(input logic [2:0] code);
    op_t op;
    case (code)
      OPC_LOAD:  op = OP_LOAD;
      OPC_READ:  op = OP_READ;
      OPC_WRITE: op = OP_WRITE;
      OPC_REGRD: op = OP_REGRD;
      OPC_EVENT: op = OP_EVENT;
      default:   op = OP_NONE;
    endcase
    return op;
  endfunction

  assign in_ch.ready = (cnt_r != 2'(FifoDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (cnt_r != 2'd0);
  assign item        = fifo_r[rptr_r];

  always_comb begin
    decoded.op         = decode(in_ch.operation);
    decoded.address    = in_ch.address;
    decoded.length     = in_ch.length;
    decoded.byte_value = in_ch.byte_value;
    decoded.nack       = in_ch.nack;
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = item_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(item_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wptr_r] <= decoded;
    end
  end

endmodule

FILE: hw/rtl/i2cq_engine.sv
`timescale 1ns / 1ps
// Back end: descriptor queue, byte store and the bus sequencer that turns
// each request into one result transfer. Uses i2cq_pkg and i2cq_out_if.
module i2cq_engine import i2cq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  parameter int STORE_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  input  item_t         item,
  output logic          item_pop,
  i2cq_out_if.source    out_ch
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int SW = $clog2(STORE_BYTES);
  localparam int IW = (SW + 1 > 9) ? SW + 1 : 9;
  localparam logic [IW-1:0] SB = IW'(STORE_BYTES);
  localparam logic [QW:0]   QD = (QW+1)'(QUEUE_DEPTH);

  logic [7:0]  store_mem [STORE_BYTES];
  logic [15:0] desc_mem  [QUEUE_DEPTH];
  logic [7:0]  st_q;
  logic [15:0] dq_q;

  state_t      state_r, state_nxt;
  after_t      after_r, after_nxt;
  item_t       item_r, item_nxt;
  result_t     res_r, res_nxt;
  result_t     out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        idle_r, idle_nxt;
  logic [7:0]  base_r, base_nxt, len_r, len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic        we_r, we_nxt;

  logic          st_we, st_re, dq_we, dq_re;
  logic [15:0]   dq_wdata;
  logic [QW-1:0] dq_waddr, dq_raddr;
  logic [QW-1:0] t1, t2, h1;
  logic [7:0]    cnt_inc;

  function automatic logic [QW-1:0] qnext(input logic [QW-1:0] p, input logic [1:0] n);
    logic [QW:0] s;
    s = (QW+1)'(p) + (QW+1)'(n);
    if (s >= QD) s = s - QD;
    return s[QW-1:0];
  endfunction

  assign t1 = qnext(tail_r, 2'd1);
  assign t2 = qnext(tail_r, 2'd2);
  assign h1 = qnext(head_r, 2'd1);
  assign cnt_inc = cnt_r + 8'd1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_r.accepted;
  assign out_ch.read_value   = out_r.read_value;
  assign out_ch.send_start   = out_r.send_start;
  assign out_ch.send_stop    = out_r.send_stop;
  assign out_ch.receive_mode = out_r.receive_mode;
  assign out_ch.nak_next     = out_r.nak_next;
  assign out_ch.tx_valid     = out_r.tx_valid;
  assign out_ch.tx_byte      = out_r.tx_byte;
  assign out_ch.stored       = out_r.stored;
  assign out_ch.engine_idle  = out_r.engine_idle;

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    idle_nxt      = idle_r;
    base_nxt      = base_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    wdata_nxt     = wdata_r;
    we_nxt        = we_r;
    item_pop      = 1'b0;
    st_we         = 1'b0;
    st_re         = 1'b0;
    dq_we         = 1'b0;
    dq_re         = 1'b0;
    dq_waddr      = tail_r;
    dq_wdata      = {item_r.length, item_r.address};
    dq_raddr      = h1;

    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop  = 1'b1;
          item_nxt  = item;
          res_nxt   = '0;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (item_r.op)
          OP_LOAD: begin
            idx_nxt   = IW'(item_r.address);
            wdata_nxt = item_r.byte_value;
            we_nxt    = 1'b1;
            after_nxt = AF_DONE;
            state_nxt = ST_MOD;
          end
          OP_READ: begin
            idx_nxt   = IW'(item_r.address);
            we_nxt    = 1'b0;
            after_nxt = AF_RVAL;
            state_nxt = ST_MOD;
          end
          OP_WRITE: begin
            if (t1 != head_r) begin
              dq_we    = 1'b1;
              tail_nxt = t1;
              res_nxt.accepted = 1'b1;
              state_nxt = ST_KICK;
            end
          end
          OP_REGRD: begin
            // two descriptors, so two free slots beyond the reserved one
            if (t2 != head_r && t2 != h1) begin
              dq_we    = 1'b1;
              dq_wdata = {REG_PTR_LEN, item_r.address};
              tail_nxt = t1;
              res_nxt.accepted = 1'b1;
              state_nxt = ST_DESC2;
            end
          end
          OP_EVENT: begin
            if (!idle_r) begin
              case (phase_r)
                PH_WRITE: begin
                  if (item_r.nack) begin
                    res_nxt.send_stop = 1'b1;
                    state_nxt = ST_ADV;
                  end else begin
                    cnt_nxt = cnt_inc;
                    if (cnt_inc >= len_r) begin
                      res_nxt.send_stop = 1'b1;
                      state_nxt = ST_ADV;
                    end else begin
                      idx_nxt   = IW'(base_r) + IW'(cnt_inc);
                      we_nxt    = 1'b0;
                      after_nxt = AF_TX;
                      state_nxt = ST_MOD;
                    end
                  end
                end
                PH_REQ: begin
                  if (item_r.nack) begin
                    res_nxt.send_stop = 1'b1;
                    state_nxt = ST_ADV;
                  end else begin
                    res_nxt.receive_mode = 1'b1;
                    res_nxt.nak_next = (len_r == REG_PTR_LEN);
                    phase_nxt = PH_READ;
                    cnt_nxt   = cnt_inc;
                  end
                end
                PH_READ: begin
                  res_nxt.nak_next = ({1'b0, cnt_r} + 9'd2 == {1'b0, len_r});
                  res_nxt.stored   = 1'b1;
                  idx_nxt   = IW'(base_r) + IW'(cnt_r);
                  wdata_nxt = item_r.byte_value;
                  we_nxt    = 1'b1;
                  state_nxt = ST_MOD;
                  if ({1'b0, cnt_r} + 9'd1 >= {1'b0, len_r}) begin
                    res_nxt.send_stop = 1'b1;
                    after_nxt = AF_ADV;
                  end else begin
                    cnt_nxt   = cnt_inc;
                    after_nxt = AF_DONE;
                  end
                end
                default: state_nxt = ST_DONE;
              endcase
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_DESC2: begin
        dq_we     = 1'b1;
        dq_wdata  = {item_r.length - REG_PTR_LEN, item_r.address + 8'd2};
        tail_nxt  = t1;
        state_nxt = ST_KICK;
      end

      ST_KICK: begin
        // an idle engine has head == old tail, so the new descriptor is current
        if (idle_r) begin
          idle_nxt  = 1'b0;
          base_nxt  = item_r.address;
          len_nxt   = (item_r.op == OP_WRITE) ? item_r.length : REG_PTR_LEN;
          idx_nxt   = IW'(item_r.address);
          we_nxt    = 1'b0;
          after_nxt = AF_BEGIN;
          state_nxt = ST_MOD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_ADV: begin
        head_nxt = h1;
        if (h1 != tail_r) begin
          dq_re     = 1'b1;
          state_nxt = ST_DRD;
        end else begin
          idle_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end
      end

      ST_DRD: begin
        base_nxt  = dq_q[7:0];
        len_nxt   = dq_q[15:8];
        idx_nxt   = IW'(dq_q[7:0]);
        we_nxt    = 1'b0;
        after_nxt = AF_BEGIN;
        state_nxt = ST_MOD;
      end

      ST_MOD: begin
        // store index wraps modulo the store size, one subtraction per cycle
        if (idx_r >= SB) begin
          idx_nxt = idx_r - SB;
        end else begin
          state_nxt = ST_MEM;
        end
      end

      ST_MEM: begin
        if (we_r) begin
          st_we     = 1'b1;
          state_nxt = (after_r == AF_ADV) ? ST_ADV : ST_DONE;
        end else begin
          st_re     = 1'b1;
          state_nxt = ST_RD;
        end
      end

      ST_RD: begin
        state_nxt = ST_DONE;
        case (after_r)
          AF_RVAL: res_nxt.read_value = st_q;
          AF_TX: begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = st_q;
          end
          AF_BEGIN: begin
            res_nxt.send_start = 1'b1;
            res_nxt.tx_valid   = 1'b1;
            res_nxt.tx_byte    = st_q;
            phase_nxt = st_q[0] ? PH_REQ : PH_WRITE;
            cnt_nxt   = 8'd0;
          end
          default: state_nxt = ST_DONE;
        endcase
      end

      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt             = res_r;
          out_nxt.engine_idle = idle_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      phase_r     <= PH_WRITE;
      cnt_r       <= 8'd0;
      idle_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      idle_r      <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    after_r <= after_nxt;
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    base_r  <= base_nxt;
    len_r   <= len_nxt;
    idx_r   <= idx_nxt;
    wdata_r <= wdata_nxt;
    we_r    <= we_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[idx_r[SW-1:0]] <= wdata_r;
    end
    if (st_re) begin
      st_q <= store_mem[idx_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dq_we) begin
      desc_mem[dq_waddr] <= dq_wdata;
    end
    if (dq_re) begin
      dq_q <= desc_mem[dq_raddr];
    end
  end

endmodule

FILE: hw/rtl/i2c_master_transaction_queue.sv
`timescale 1ns / 1ps
// Queued I2C master sequencer, top level. Instantiates i2cq_front and
// i2cq_engine; uses i2cq_pkg and the channel interfaces in i2cq_if.
//
// Requests are taken one per cycle, while there is room, into a two-entry
// queue; the engine then works on one request at a time and returns exactly
// one result per request. The longest engine pass comes when a received byte
// ends a read and the next descriptor starts: the single-port byte store and
// the descriptor memory each have a registered read, and the store index is
// wrapped modulo STORE_BYTES by one subtraction per cycle (none needed when
// STORE_BYTES >= 512). A stalled result sink holds the engine until its
// pending result is taken.
// A full descriptor queue refuses an enqueue with accepted low.
module i2c_master_transaction_queue import i2cq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  parameter int STORE_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  i2cq_in_if.sink     in_ch,
  i2cq_out_if.source  out_ch
);

  logic  item_valid;
  logic  item_pop;
  item_t item;

  i2cq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  i2cq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STORE_BYTES (STORE_BYTES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_ch     (out_ch)
  );

endmodule
